// ===== rtl/core/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types, codes and constants of the glob pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

    localparam int MAX_TOKENS = 32;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        REQ_PAT_BYTE  = 2'd0,
        REQ_PAT_END   = 2'd1,
        REQ_NAME_BYTE = 2'd2,
        REQ_NAME_END  = 2'd3
    } req_code_t;

    typedef enum logic [2:0] {
        TK_LIT      = 3'd0,
        TK_STAR     = 3'd1,
        TK_STARSTAR = 3'd2,
        TK_SSSLASH  = 3'd3,
        TK_QUEST    = 3'd4
    } tok_kind_t;

    // One request word as it leaves the input register.
    typedef struct packed {
        logic       fire;
        req_code_t  req;
        logic [7:0] data;
    } step_t;

    function automatic logic is_star_kind(input tok_kind_t k);
        return k inside {TK_STAR, TK_STARSTAR, TK_SSSLASH};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpm_if.sv =====
// ----------------------------------------------------------------------------
// gpm_if
// Valid/ready channels of the glob pattern matcher: requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface gpm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gpm_tokenizer.sv =====
// ----------------------------------------------------------------------------
// gpm_tokenizer
// Splits pattern bytes into tokens with a two-star lookahead and keeps the
// token store, the token count, the overflow flag and the start set.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_tokenizer #(
    parameter  int MaxTokens = gpm_pkg::MAX_TOKENS,
    localparam int TW        = $clog2(MaxTokens + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  gpm_pkg::step_t       step,
    output gpm_pkg::tok_kind_t   kinds_eff [MaxTokens],
    output logic [7:0]           chars     [MaxTokens],
    output logic [TW-1:0]        total_eff,
    output logic [MaxTokens:0]   start_eff,
    output logic                 ovf_eff
);

    localparam logic [MaxTokens:0] StartInit = (MaxTokens + 1)'(1);
    localparam logic [TW-1:0]      TokLimit  = TW'(MaxTokens);

    gpm_pkg::tok_kind_t kinds_reg [MaxTokens];
    logic [7:0]         chars_reg [MaxTokens];
    logic [TW-1:0]      total_reg;
    logic [1:0]         la_reg;
    logic               ovf_reg;
    logic               closed_reg;
    logic [MaxTokens:0] start_reg;
    logic               run_reg;

    logic               is_pat;
    logic               restart;
    logic               do_close;
    logic [TW-1:0]      b_total;
    logic [1:0]         b_la;
    logic               b_ovf;
    logic [MaxTokens:0] b_start;
    logic               b_run;
    logic               a_en;
    logic               a_wr;
    gpm_pkg::tok_kind_t a_kind;
    logic               b_en;
    logic               b_wr;
    gpm_pkg::tok_kind_t b_kind;
    logic [1:0]         la_next;
    logic [TW-1:0]      t1;
    logic [TW-1:0]      total_next;
    logic               run_next;
    logic [MaxTokens:0] start_next;

    always_comb
    begin
        is_pat   = (step.req == gpm_pkg::REQ_PAT_BYTE);
        restart  = is_pat && closed_reg;
        do_close = !is_pat && !closed_reg;
        b_total  = restart ? '0 : total_reg;
        b_la     = restart ? 2'd0 : la_reg;
        b_ovf    = restart ? 1'b0 : ovf_reg;
        b_start  = restart ? StartInit : start_reg;
        b_run    = restart ? 1'b1 : run_reg;

        a_en    = 1'b0;
        a_kind  = gpm_pkg::TK_STAR;
        b_en    = 1'b0;
        b_kind  = gpm_pkg::TK_LIT;
        la_next = b_la;

        if (is_pat)
        begin
            if (b_la == 2'd1 && step.data == gpm_pkg::CHAR_STAR)
            begin
                la_next = 2'd2;
            end
            else if (b_la == 2'd2 && step.data == gpm_pkg::CHAR_SLASH)
            begin
                a_en    = 1'b1;
                a_kind  = gpm_pkg::TK_SSSLASH;
                la_next = 2'd0;
            end
            else
            begin
                if (b_la == 2'd1)
                begin
                    a_en   = 1'b1;
                    a_kind = gpm_pkg::TK_STAR;
                end
                else if (b_la == 2'd2)
                begin
                    a_en   = 1'b1;
                    a_kind = gpm_pkg::TK_STARSTAR;
                end
                if (step.data == gpm_pkg::CHAR_STAR)
                begin
                    la_next = 2'd1;
                end
                else
                begin
                    la_next = 2'd0;
                    b_en    = 1'b1;
                    b_kind  = (step.data == gpm_pkg::CHAR_QUEST) ? gpm_pkg::TK_QUEST
                                                                 : gpm_pkg::TK_LIT;
                end
            end
        end
        else if (do_close)
        begin
            la_next = 2'd0;
            if (b_la == 2'd1)
            begin
                a_en   = 1'b1;
                a_kind = gpm_pkg::TK_STAR;
            end
            else if (b_la == 2'd2)
            begin
                a_en   = 1'b1;
                a_kind = gpm_pkg::TK_STARSTAR;
            end
        end

        a_wr       = a_en && (b_total < TokLimit);
        t1         = b_total + TW'(a_wr);
        b_wr       = b_en && (t1 < TokLimit);
        total_next = t1 + TW'(b_wr);
        ovf_eff    = b_ovf || (a_en && !a_wr) || (b_en && !b_wr);

        // The start set covers the leading run of star-like tokens, since the
        // closure from position zero walks through exactly those.
        start_next = b_start;
        run_next   = b_run;
        if (a_wr)
        begin
            if (run_next && gpm_pkg::is_star_kind(a_kind))
            begin
                for (int j = 1; j <= MaxTokens; j++)
                begin
                    if (j == int'(b_total) + 1)
                    begin
                        start_next[j] = 1'b1;
                    end
                end
            end
            else
            begin
                run_next = 1'b0;
            end
        end
        if (b_wr)
        begin
            if (run_next && gpm_pkg::is_star_kind(b_kind))
            begin
                for (int j = 1; j <= MaxTokens; j++)
                begin
                    if (j == int'(t1) + 1)
                    begin
                        start_next[j] = 1'b1;
                    end
                end
            end
            else
            begin
                run_next = 1'b0;
            end
        end

        // A name item that closes the pattern sees the flushed star token now.
        for (int i = 0; i < MaxTokens; i++)
        begin
            kinds_eff[i] = (a_wr && TW'(i) == b_total) ? a_kind : kinds_reg[i];
            chars[i]     = chars_reg[i];
        end
        total_eff = total_next;
        start_eff = start_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxTokens; i++)
        begin
            if (step.fire && a_wr && TW'(i) == b_total)
            begin
                kinds_reg[i] <= a_kind;
                chars_reg[i] <= 8'd0;
            end
            else if (step.fire && b_wr && TW'(i) == t1)
            begin
                kinds_reg[i] <= b_kind;
                chars_reg[i] <= step.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            la_reg     <= 2'd0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b0;
            start_reg  <= StartInit;
            run_reg    <= 1'b1;
        end
        else if (step.fire)
        begin
            total_reg  <= total_next;
            la_reg     <= la_next;
            ovf_reg    <= ovf_eff;
            closed_reg <= !is_pat;
            start_reg  <= start_next;
            run_reg    <= run_next;
        end
    end

`ifndef SYNTH
    a_closed_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> la_reg == 2'd0)
        else $error("pending stars left in a closed pattern");

    a_start_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        (start_reg >> (int'(total_reg) + 1)) == '0)
        else $error("start set reaches past the last token");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/gpm_nfa.sv =====
// ----------------------------------------------------------------------------
// gpm_nfa
// Bit-parallel NFA over the token positions: one name byte per step,
// followed by the epsilon closure, plus the end-of-name decision.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_nfa #(
    parameter  int MaxTokens = gpm_pkg::MAX_TOKENS,
    localparam int TW        = $clog2(MaxTokens + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  gpm_pkg::step_t       step,
    input  gpm_pkg::tok_kind_t   kinds [MaxTokens],
    input  wire [7:0]            chars [MaxTokens],
    input  wire [TW-1:0]         total,
    input  wire [MaxTokens:0]    start,
    input  wire                  ovf,
    output logic                 hit
);

    logic [MaxTokens:0] active_reg;
    logic [MaxTokens:0] mid_reg;
    logic               open_reg;
    logic               dead_reg;

    logic [MaxTokens:0] base_act;
    logic [MaxTokens:0] base_mid;
    logic               base_dead;
    logic [MaxTokens:0] act;
    logic [MaxTokens:0] bnd;
    logic [MaxTokens:0] mid_s;
    logic [MaxTokens:0] prop;
    logic [MaxTokens:0] gen;
    logic [MaxTokens:0] sum;
    logic [MaxTokens:0] reach;
    logic [MaxTokens:0] step_act;
    logic [MaxTokens:0] step_mid;
    logic               not_slash;

    always_comb
    begin
        base_act  = open_reg ? active_reg : start;
        base_mid  = open_reg ? mid_reg : '0;
        base_dead = open_reg && dead_reg;
        not_slash = (step.data != gpm_pkg::CHAR_SLASH);

        act = '0;
        bnd = '0;
        for (int i = 0; i < MaxTokens; i++)
        begin
            if (TW'(i) < total && base_act[i])
            begin
                case (kinds[i])
                    gpm_pkg::TK_LIT:
                    begin
                        if (step.data == chars[i])
                        begin
                            act[i+1] = 1'b1;
                            bnd[i+1] = 1'b1;
                        end
                    end
                    gpm_pkg::TK_QUEST:
                    begin
                        if (not_slash)
                        begin
                            act[i+1] = 1'b1;
                            bnd[i+1] = 1'b1;
                        end
                    end
                    gpm_pkg::TK_STAR:
                    begin
                        if (not_slash)
                        begin
                            act[i] = 1'b1;
                            bnd[i] = 1'b1;
                        end
                    end
                    gpm_pkg::TK_STARSTAR:
                    begin
                        act[i] = 1'b1;
                        bnd[i] = 1'b1;
                    end
                    gpm_pkg::TK_SSSLASH:
                    begin
                        act[i] = 1'b1;
                        if (!not_slash)
                        begin
                            bnd[i] = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        mid_s = act & ~bnd;

        // The closure is a carry chain: a star-like token propagates an
        // active position forward, and a reached position is at a boundary,
        // so a segment-star passes it on too. One add resolves the chain.
        prop = '0;
        gen  = '0;
        for (int i = 0; i < MaxTokens; i++)
        begin
            if (TW'(i) < total && gpm_pkg::is_star_kind(kinds[i]))
            begin
                prop[i] = 1'b1;
                gen[i]  = act[i] && (kinds[i] != gpm_pkg::TK_SSSLASH || !mid_s[i]);
            end
        end
        sum      = prop + gen;
        reach    = sum ^ prop ^ gen;
        step_act = act | reach;
        step_mid = mid_s & ~reach;

        hit = !base_dead && !ovf && base_act[total];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            mid_reg    <= '0;
            open_reg   <= 1'b0;
            dead_reg   <= 1'b0;
        end
        else if (step.fire)
        begin
            case (step.req)
                gpm_pkg::REQ_PAT_BYTE:
                begin
                    open_reg   <= 1'b0;
                    dead_reg   <= 1'b0;
                    active_reg <= '0;
                    mid_reg    <= '0;
                end
                gpm_pkg::REQ_NAME_BYTE:
                begin
                    open_reg <= 1'b1;
                    if (base_dead)
                    begin
                        active_reg <= base_act;
                        mid_reg    <= base_mid;
                        dead_reg   <= 1'b1;
                    end
                    else
                    begin
                        active_reg <= step_act;
                        mid_reg    <= step_mid;
                        dead_reg   <= (act == '0);
                    end
                end
                gpm_pkg::REQ_NAME_END:
                begin
                    open_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_dead_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |-> active_reg == '0)
        else $error("dead name still has active positions");

    a_live_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg && !dead_reg |-> active_reg != '0)
        else $error("live name has no active position");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/glob_pattern_nfa_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_pattern_nfa_matcher
// Glob matcher: tokenizes pattern bytes, then runs name bytes through a
// bit-parallel NFA and reports a match at each end of name.
// ----------------------------------------------------------------------------
// A request word is registered, then processed by the tokenizer and the
// NFA, which update their state registers at the end of the cycle in which
// they process it; an end-of-name result is written to the output register
// at that same edge. The block takes one request word per clock; the only
// stall comes when an end of name waits in the input register while the output
// register still holds a result that has not been taken. The token store holds
// MaxTokens entries in flip-flops and the NFA evaluates all of them in
// parallel, so pattern length does not change the rate.
`default_nettype none

module glob_pattern_nfa_matcher #(
    parameter int MaxTokens = gpm_pkg::MAX_TOKENS
) (
    input  wire          clk,
    input  wire          rst_n,
    gpm_req_if.sink      req,
    gpm_rsp_if.source    rsp
);

    localparam int TW = $clog2(MaxTokens + 1);

    logic                in_vld_reg;
    gpm_pkg::req_code_t  req_reg;
    logic [7:0]          byte_reg;
    logic                out_vld_reg;
    logic                matched_reg;
    logic                ovf_reg;

    logic                fire;
    logic                in_acc;
    gpm_pkg::step_t      step;

    gpm_pkg::tok_kind_t  kinds_eff [MaxTokens];
    logic [7:0]          chars     [MaxTokens];
    logic [TW-1:0]       total_eff;
    logic [MaxTokens:0]  start_eff;
    logic                ovf_eff;
    logic                hit;

    always_comb
    begin
        fire = in_vld_reg &&
               (req_reg != gpm_pkg::REQ_NAME_END || !out_vld_reg || rsp.ready);
        in_acc    = req.valid && req.ready;
        step.fire = fire;
        step.req  = req_reg;
        step.data = byte_reg;
    end

    assign req.ready            = !in_vld_reg || fire;
    assign rsp.valid            = out_vld_reg;
    assign rsp.matched          = matched_reg;
    assign rsp.pattern_overflow = ovf_reg;

    gpm_tokenizer #(
        .MaxTokens (MaxTokens)
    ) u_tokenizer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .kinds_eff (kinds_eff),
        .chars     (chars),
        .total_eff (total_eff),
        .start_eff (start_eff),
        .ovf_eff   (ovf_eff)
    );

    gpm_nfa #(
        .MaxTokens (MaxTokens)
    ) u_nfa (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .kinds (kinds_eff),
        .chars (chars),
        .total (total_eff),
        .start (start_eff),
        .ovf   (ovf_eff),
        .hit   (hit)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg  <= gpm_pkg::req_code_t'(req.req_type);
            byte_reg <= req.data_byte;
        end
        if (fire && req_reg == gpm_pkg::REQ_NAME_END)
        begin
            matched_reg <= hit;
            ovf_reg     <= ovf_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end

            if (fire && req_reg == gpm_pkg::REQ_NAME_END)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && ovf_reg |-> !matched_reg)
        else $error("match reported for an overflowed pattern");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !rsp.ready |=> out_vld_reg && $stable(matched_reg))
        else $error("held result dropped or changed");
`endif

endmodule

`default_nettype wire
